FILE: rtl/qpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qpd_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;

  // Register values after reset.
  localparam logic [7:0]         PROP_GAIN_RST      = 8'd20;
  localparam logic [7:0]         INTEG_GAIN_RST     = 8'd0;
  localparam logic [7:0]         DERIV_GAIN_RST     = 8'd0;
  localparam logic signed [15:0] ERROR_OFFSET_RST   = 16'sd500;
  localparam logic signed [15:0] START_OFFSET_RST   = -16'sd35;
  localparam logic [15:0]        INTEGRAL_LIMIT_RST = 16'd1000;

  // Item kinds carried in tuser.
  localparam logic OP_ENCODER = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Position scale: 720 degrees per 8400 counts is 3/35 degree per count.
  localparam int POS_MUL = 3;
  localparam int POS_DIV = 35;

  // Error and integral are held as signed 26-bit values.
  localparam int ERR_W = 26;
  localparam logic signed [ERR_W-1:0] ERR_MAX = 26'sh1FFFFFF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = -26'sh2000000;

  localparam int TICK_RATE = 100;
  localparam int DRIVE_MAX = 255;

  // Duty quotients by reciprocal multiply: forward divides by 100,
  // reverse divides by 600 (5/6 of the drive, in hundredths).
  localparam int RECIP_SH = 27;
  localparam int RECIP_W  = 21;
  localparam logic [RECIP_W-1:0] RECIP_FWD = 21'd1342178;
  localparam logic [RECIP_W-1:0] RECIP_REV = 21'd223697;

  // One encoder sample handed to the counter.
  typedef struct packed {
    logic en;
    logic phase_a;
    logic phase_b;
  } enc_step_t;

endpackage

`default_nettype wire

FILE: rtl/quadrature_position_pid_drive_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Quadrature encoder counter and PID position loop for a DC motor bridge.
// Each input word is either an encoder sample (tuser 0: phase A and B levels)
// or a control tick (tuser 1: a set point in degrees). Samples update the
// 16-bit count and produce no output; each tick produces one output word with
// the measured position in degrees, the drive direction and the PWM duty.
// The block takes one word every clock: in_tready drops only when both the
// output register and its skid register hold results that the sink has not
// taken. A tick's result reaches out_tvalid through a pipeline of an input
// register, six compute stages and the output register; that depth is set
// by the chain of 8x26 gain products, the integral update and the duty
// quotient. Encoder samples take effect in the input stage, so a tick always
// sees every sample accepted before it.
// Configuration writes land at once and are meant for idle periods.

module quadrature_position_pid_drive_core #(
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [0] phase_a, [1] phase_b, [17:2] target, [23:18] zero
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,
  // in_tuser: [0] op (0 encoder sample, 1 control tick)
  input  logic                             in_tuser,
  // out_tdata: [15:0] position_deg, [16] reverse, [24:17] duty, [31:25] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);
  import qpd_pkg::*;

  localparam int QW   = FRAC_BITS + 14;
  localparam int PW   = FRAC_BITS + 18;
  localparam int EW   = (FRAC_BITS + 20 > 27) ? FRAC_BITS + 20 : 27;
  localparam int DEGW = PW - FRAC_BITS;
  localparam int KW   = 35;
  localparam int DFW  = ERR_W + 1;
  localparam int KDW  = DFW + 9;
  localparam int SW   = 36;
  localparam int PDW  = 44;
  localparam int SUMW = 52;
  localparam int DW   = FRAC_BITS + 16;
  localparam int MAGW = DW + 3;
  localparam int UW   = 17;
  localparam int MW   = UW + RECIP_W;

  localparam longint DMAX = longint'(DRIVE_MAX) * TICK_RATE * (longint'(1) << FRAC_BITS);
  localparam logic signed [SUMW-1:0] DMAX_S = SUMW'(DMAX);
  localparam logic signed [DEGW-1:0] DEG_HI = DEGW'(32767);
  localparam logic signed [DEGW-1:0] DEG_LO = DEGW'(-32768);
  localparam logic [7:0] REV_DUTY_MAX = 8'((DRIVE_MAX * 5) / 6);

  // Configuration registers.
  logic [7:0]         kp_r, ki_r, kd_r;
  logic signed [15:0] eoff_r, soff_r;
  logic [15:0]        ilim_r;

  // Pipeline control.
  logic en;
  logic s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r;

  // Stage payloads.
  logic                   s0_op_r, s0_a_r, s0_b_r;
  logic [15:0]            s0_tgt_r, s1_tgt_r;
  logic signed [PW-1:0]   s1_pos_r;
  logic signed [ERR_W-1:0] s2_err_r;
  logic signed [15:0]     s2_deg_r, s3_deg_r, s4_deg_r, s5_deg_r, s6_deg_r;
  logic signed [KW-1:0]   s3_kp_err_r, s3_ki_err_r;
  logic signed [KDW-1:0]  s3_kd_diff_r;
  logic signed [ERR_W-1:0] s4_integ_r;
  logic signed [PDW-1:0]  s4_pd_r;
  logic signed [DW-1:0]   s5_d_r;
  logic [UW-1:0]          s6_u_r;
  logic                   s6_neg_r, s6_zero_r;

  // Loop state.
  logic signed [ERR_W-1:0] prev_err_r, integral_r;
  logic                    held_dir_r;
  logic [7:0]              held_duty_r;

  // Output register and skid register.
  logic        out_vld_r, skid_vld_r;
  logic [31:0] out_data_r, skid_data_r;

  // Encoder counter.
  enc_step_t            enc_step;
  logic signed [QW-1:0] enc_fq;
  logic                 enc_rem_nz, enc_cnt_neg;

  // Combinational stage results.
  logic signed [QW-1:0]    trunc_q;
  logic signed [PW-1:0]    pos_nxt;
  logic signed [EW-1:0]    err_raw;
  logic signed [ERR_W-1:0] err_nxt;
  logic signed [DEGW-1:0]  deg_q, deg_fix;
  logic signed [15:0]      deg_nxt;
  logic signed [KW-1:0]    kp_nxt, ki_nxt;
  logic signed [DFW-1:0]   diff;
  logic signed [KDW-1:0]   kd_nxt;
  logic signed [SW-1:0]    isum, lim_s, ihi, ilo, iclamp;
  logic signed [ERR_W-1:0] integ_nxt;
  logic signed [PDW-1:0]   pd_nxt;
  logic signed [SUMW-1:0]  dsum, dclamp;
  logic signed [DW-1:0]   d_nxt;
  logic                   dneg, dzero;
  logic [DW-1:0]          dmag;
  logic [MAGW-1:0]        mag5;
  logic [UW-1:0]          u_nxt;
  logic [MW-1:0]          prod;
  logic [7:0]             quot;
  logic                   res_dir;
  logic [7:0]             res_duty;
  logic [31:0]            res_word;
  logic                   push, take;

  // The pipeline moves whenever the skid register is free.
  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= PROP_GAIN_RST;
      ki_r   <= INTEG_GAIN_RST;
      kd_r   <= DERIV_GAIN_RST;
      eoff_r <= ERROR_OFFSET_RST;
      soff_r <= START_OFFSET_RST;
      ilim_r <= INTEGRAL_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:      kp_r   <= cfg_data[7:0];
        REG_INTEG_GAIN:     ki_r   <= cfg_data[7:0];
        REG_DERIV_GAIN:     kd_r   <= cfg_data[7:0];
        REG_ERROR_OFFSET:   eoff_r <= $signed(cfg_data);
        REG_START_OFFSET:   soff_r <= $signed(cfg_data);
        REG_INTEGRAL_LIMIT: ilim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Encoder samples are applied from the input register.
  assign enc_step.en      = en && s0_vld_r && (s0_op_r == OP_ENCODER);
  assign enc_step.phase_a = s0_a_r;
  assign enc_step.phase_b = s0_b_r;

  qpd_enc #(
    .FRAC_BITS (FRAC_BITS)
  ) u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (enc_step),
    .fq_o      (enc_fq),
    .rem_nz_o  (enc_rem_nz),
    .cnt_neg_o (enc_cnt_neg)
  );

  always_comb begin
    // Stage 1: position in fixed point, truncated toward zero.
    trunc_q = enc_fq + $signed({{(QW-1){1'b0}}, enc_cnt_neg & enc_rem_nz});
    pos_nxt = PW'(trunc_q) + (PW'(soff_r) <<< FRAC_BITS);

    // Stage 2: saturated error and position in whole degrees.
    err_raw = $signed({{(EW-16-FRAC_BITS){1'b0}}, s1_tgt_r, {FRAC_BITS{1'b0}}})
              - EW'(s1_pos_r) - (EW'(eoff_r) <<< FRAC_BITS);
    if (err_raw > EW'(ERR_MAX)) begin
      err_nxt = ERR_MAX;
    end else if (err_raw < EW'(ERR_MIN)) begin
      err_nxt = ERR_MIN;
    end else begin
      err_nxt = ERR_W'(err_raw);
    end
    deg_q   = DEGW'(s1_pos_r >>> FRAC_BITS);
    deg_fix = deg_q + $signed({{(DEGW-1){1'b0}},
                               s1_pos_r[PW-1] & (|s1_pos_r[FRAC_BITS-1:0])});
    if (deg_fix > DEG_HI) begin
      deg_nxt = 16'(DEG_HI);
    end else if (deg_fix < DEG_LO) begin
      deg_nxt = 16'(DEG_LO);
    end else begin
      deg_nxt = 16'(deg_fix);
    end

    // Stage 3: gain products.
    kp_nxt = $signed({1'b0, kp_r}) * s2_err_r;
    ki_nxt = $signed({1'b0, ki_r}) * s2_err_r;
    diff   = DFW'(prev_err_r) - DFW'(s2_err_r);
    kd_nxt = $signed({1'b0, kd_r}) * diff;

    // Stage 4: integral with its clamp, and the P plus D term.
    isum  = SW'(integral_r) + SW'(s3_ki_err_r);
    lim_s = $signed(SW'({ilim_r, {FRAC_BITS{1'b0}}}));
    ihi   = (lim_s > SW'(ERR_MAX)) ? SW'(ERR_MAX) : lim_s;
    ilo   = (-lim_s < SW'(ERR_MIN)) ? SW'(ERR_MIN) : -lim_s;
    if (isum > ihi) begin
      iclamp = ihi;
    end else if (isum < ilo) begin
      iclamp = ilo;
    end else begin
      iclamp = isum;
    end
    integ_nxt = ERR_W'(iclamp);
    pd_nxt    = PDW'(s3_kp_err_r) + PDW'(s3_kd_diff_r) * PDW'(TICK_RATE);

    // Stage 5: drive in hundredths, clamped to the bridge range.
    dsum = SUMW'(s4_pd_r) * SUMW'(TICK_RATE) + SUMW'(s4_integ_r);
    if (dsum > DMAX_S) begin
      dclamp = DMAX_S;
    end else if (dsum < -DMAX_S) begin
      dclamp = -DMAX_S;
    end else begin
      dclamp = dsum;
    end
    d_nxt = DW'(dclamp);

    // Stage 6: whole units of drive (reverse is scaled by five here; the divide by 600 makes it five sixths).
    dneg  = s5_d_r[DW-1];
    dzero = s5_d_r == '0;
    dmag  = dneg ? DW'(-s5_d_r) : DW'(s5_d_r);
    mag5  = MAGW'({dmag, 2'b00}) + MAGW'(dmag);
    u_nxt = dneg ? UW'(mag5 >> FRAC_BITS) : UW'(dmag >> FRAC_BITS);

    // Last step: divide by 100 or 600 through a reciprocal; a zero drive
    // keeps the held direction and duty.
    prod     = MW'(s6_u_r) * MW'(s6_neg_r ? RECIP_REV : RECIP_FWD);
    quot     = prod[RECIP_SH +: 8];
    res_dir  = s6_zero_r ? held_dir_r : s6_neg_r;
    res_duty = s6_zero_r ? held_duty_r : quot;
    res_word = {7'b0, res_duty, res_dir, s6_deg_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
      s1_vld_r <= s0_vld_r && (s0_op_r == OP_TICK);
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_op_r      <= in_tuser;
      s0_a_r       <= in_tdata[0];
      s0_b_r       <= in_tdata[1];
      s0_tgt_r     <= in_tdata[17:2];
      s1_tgt_r     <= s0_tgt_r;
      s1_pos_r     <= pos_nxt;
      s2_err_r     <= err_nxt;
      s2_deg_r     <= deg_nxt;
      s3_kp_err_r  <= kp_nxt;
      s3_ki_err_r  <= ki_nxt;
      s3_kd_diff_r <= kd_nxt;
      s3_deg_r     <= s2_deg_r;
      s4_integ_r   <= integ_nxt;
      s4_pd_r      <= pd_nxt;
      s4_deg_r     <= s3_deg_r;
      s5_d_r       <= d_nxt;
      s5_deg_r     <= s4_deg_r;
      s6_u_r       <= u_nxt;
      s6_neg_r     <= dneg;
      s6_zero_r    <= dzero;
      s6_deg_r     <= s5_deg_r;
    end
  end

  // Loop state advances as each tick passes the stage that owns it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r  <= '0;
      integral_r  <= '0;
      held_dir_r  <= 1'b0;
      held_duty_r <= '0;
    end else if (en) begin
      if (s2_vld_r) begin
        prev_err_r <= s2_err_r;
      end
      if (s3_vld_r) begin
        integral_r <= integ_nxt;
      end
      if (s6_vld_r && !s6_zero_r) begin
        held_dir_r  <= s6_neg_r;
        held_duty_r <= quot;
      end
    end
  end

  // Output register with a skid register behind it.
  assign push = en && s6_vld_r;
  assign take = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_vld_r || take) begin
        out_data_r <= res_word;
      end else begin
        skid_data_r <= res_word;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full while output register is empty");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s6_vld_r && !skid_vld_r) |=> out_vld_r)
    else $error("finished tick result did not reach the output");

  a_reverse_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r[16]) |-> (out_data_r[24:17] <= REV_DUTY_MAX))
    else $error("reverse duty above its scaled maximum");

endmodule

`default_nettype wire

FILE: rtl/qpd_enc.sv
`timescale 1ns / 1ps
`default_nettype none

module qpd_enc #(
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qpd_pkg::enc_step_t          step_i,
  output logic signed [FRAC_BITS+13:0] fq_o,
  output logic                        rem_nz_o,
  output logic                        cnt_neg_o
);
  import qpd_pkg::*;

  localparam int QW = FRAC_BITS + 14;

  // The position numerator count*3*S is tracked as floor quotient and
  // remainder over 35, so each count step is a small add.
  localparam longint STEP   = POS_MUL * (longint'(1) << FRAC_BITS);
  localparam longint QD     = STEP / POS_DIV;
  localparam longint RD     = STEP % POS_DIV;
  localparam longint NMAX   = 32767 * STEP;
  localparam longint FQ_MAX = NMAX / POS_DIV;
  localparam longint R_MAX  = NMAX % POS_DIV;
  localparam longint PMIN   = 32768 * STEP;
  localparam longint FQ_MIN = -((PMIN + POS_DIV - 1) / POS_DIV);
  localparam longint R_MIN  = (POS_DIV - (PMIN % POS_DIV)) % POS_DIV;

  localparam logic [15:0] CNT_TOP = 16'h7FFF;
  localparam logic [15:0] CNT_BOT = 16'h8000;

  logic                 last_a_r;
  logic [15:0]          cnt_r, cnt_nxt;
  logic signed [QW-1:0] fq_r, fq_nxt;
  logic [5:0]           rem_r, rem_nxt;
  logic                 hit, up;
  logic [6:0]           rsum;

  assign hit = step_i.en && (step_i.phase_a != last_a_r);
  assign up  = step_i.phase_b != step_i.phase_a;
  assign rsum = {1'b0, rem_r} + 7'(RD);

  always_comb begin
    cnt_nxt = cnt_r;
    fq_nxt  = fq_r;
    rem_nxt = rem_r;
    if (hit && up) begin
      cnt_nxt = cnt_r + 16'd1;
      if (cnt_r == CNT_TOP) begin
        fq_nxt  = QW'(FQ_MIN);
        rem_nxt = 6'(R_MIN);
      end else if (rsum >= 7'(POS_DIV)) begin
        fq_nxt  = fq_r + QW'(QD + 1);
        rem_nxt = 6'(rsum - 7'(POS_DIV));
      end else begin
        fq_nxt  = fq_r + QW'(QD);
        rem_nxt = rsum[5:0];
      end
    end else if (hit) begin
      cnt_nxt = cnt_r - 16'd1;
      if (cnt_r == CNT_BOT) begin
        fq_nxt  = QW'(FQ_MAX);
        rem_nxt = 6'(R_MAX);
      end else if (rem_r >= 6'(RD)) begin
        fq_nxt  = fq_r - QW'(QD);
        rem_nxt = rem_r - 6'(RD);
      end else begin
        fq_nxt  = fq_r - QW'(QD + 1);
        rem_nxt = rem_r + 6'(POS_DIV - RD);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r <= 1'b0;
      cnt_r    <= '0;
      fq_r     <= '0;
      rem_r    <= '0;
    end else begin
      if (step_i.en) begin
        last_a_r <= step_i.phase_a;
      end
      cnt_r <= cnt_nxt;
      fq_r  <= fq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign fq_o      = fq_r;
  assign rem_nz_o  = rem_r != '0;
  assign cnt_neg_o = cnt_r[15];

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < 6'(POS_DIV))
    else $error("position remainder out of range");

  a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[15] == fq_r[QW-1])
    else $error("position quotient sign disagrees with count");

  a_zero_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (fq_r == '0 && rem_r == '0))
    else $error("zero count with nonzero position");

endmodule

`default_nettype wire

FILE: tb/sv/quadrature_position_pid_drive_core_tb.sv
`timescale 1ns / 1ps

module quadrature_position_pid_drive_core_tb;
  import qpd_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam longint SCALE = longint'(1) << FRAC_BITS;

  // Idle clocks waited after the last result, enough for anything still in
  // flight to leave the pipeline.
  localparam int DRAIN_CYCLES = 16;
  // The long sink hold-off used to fill the block and push back on the source.
  localparam int HOLD_CYCLES = 300;
  // The slowest legal run stays far below this count.
  localparam int CYCLE_LIMIT = 400000;

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  typedef enum int {SINK_ALWAYS, SINK_COIN, SINK_MOSTLY, SINK_PERIODIC} sink_mode_t;
  typedef enum int {CFG_RANDOM, CFG_HIGH, CFG_LOW} cfg_choice_t;

  // One predicted output word, field by field.
  typedef struct packed {
    logic signed [15:0] position_deg;
    logic               reverse;
    logic [7:0]         duty;
  } drive_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // Predicted results waiting for their output word, oldest first.
  drive_result_t pending_results[$];

  int   cycle_count;
  int   mismatch_count;
  int   burst_left;
  bit   idle_on;
  bit   hold_req;

  // The predictor's own copy of the registers and of the block state.
  logic [7:0]         kp_m, ki_m, kd_m;
  logic signed [15:0] eoff_m, soff_m;
  logic [15:0]        ilim_m;
  logic               last_a_m;
  logic [15:0]        count_m;
  longint             integ_m, prev_err_m;
  logic               dir_m;
  logic [7:0]         duty_m;

  quadrature_position_pid_drive_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The run ends here if the stimulus or the drain never completes.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("quadrature_position_pid_drive_core_tb: FAIL");
    $finish;
  end

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s at cycle %0d: got %0d, predicted %0d",
             what, cycle_count, got, want);
    mismatch_count++;
  endtask

  // Advances the predictor by one accepted input word. An encoder sample only
  // moves the count; a control tick runs the PID loop and queues one result.
  task automatic predict_word(input logic op, input logic a, input logic b,
                              input logic [15:0] tgt);
    longint        cnt, pos_q, err_q, lim, drive, drive_max;
    drive_result_t res;
    if (op == OP_ENCODER) begin
      // Phase B only matters when phase A has moved.
      if (a != last_a_m) begin
        count_m = (b != a) ? count_m + 16'd1 : count_m - 16'd1;
      end
      last_a_m = a;
    end else begin
      cnt   = longint'($signed(count_m));
      pos_q = (cnt * POS_MUL * SCALE) / POS_DIV + longint'(soff_m) * SCALE;
      err_q = longint'(tgt) * SCALE - pos_q - longint'(eoff_m) * SCALE;
      err_q = clamp_to(err_q, longint'(ERR_MIN), longint'(ERR_MAX));

      lim     = longint'(ilim_m) * SCALE;
      integ_m = integ_m + longint'(ki_m) * err_q;
      integ_m = clamp_to(integ_m, -lim, lim);
      integ_m = clamp_to(integ_m, longint'(ERR_MIN), longint'(ERR_MAX));

      // The drive is kept in hundredths of a scaled unit so that the
      // integral term needs no division.
      drive = TICK_RATE * (longint'(kp_m) * err_q
              + longint'(kd_m) * TICK_RATE * (prev_err_m - err_q)) + integ_m;
      prev_err_m = err_q;
      drive_max  = DRIVE_MAX * TICK_RATE * SCALE;
      drive      = clamp_to(drive, -drive_max, drive_max);

      // A drive of exactly zero leaves direction and duty as they were.
      if (drive > 0) begin
        dir_m  = 1'b0;
        duty_m = 8'(drive / (TICK_RATE * SCALE));
      end else if (drive < 0) begin
        dir_m  = 1'b1;
        duty_m = 8'(((-drive) * 5) / (6 * TICK_RATE * SCALE));
      end

      res.position_deg = 16'(clamp_to(pos_q / SCALE, -32768, 32767));
      res.reverse      = dir_m;
      res.duty         = duty_m;
      pending_results.push_back(res);
    end
  endtask

  // Offers one input word and returns at the edge where it is accepted. The
  // source works in bursts; tvalid drops only at the start of a gap, so it is
  // never lowered and raised within one time step.
  task automatic send_word(input logic op, input logic a, input logic b,
                           input logic [15:0] tgt);
    int gap;
    if (burst_left == 0) begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'b0, tgt, b, a};
    do @(posedge clk); while (!in_tready);
    predict_word(op, a, b, tgt);
  endtask

  // Stops the source and waits until every predicted word has arrived, then
  // lets the pipeline drain of samples that produce no output.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register and mirrors the write in the predictor. The caller
  // lowers cfg_valid after its last write so back-to-back writes keep it high.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PROP_GAIN:      kp_m   = value[7:0];
      REG_INTEG_GAIN:     ki_m   = value[7:0];
      REG_DERIV_GAIN:     kd_m   = value[7:0];
      REG_ERROR_OFFSET:   eoff_m = value;
      REG_START_OFFSET:   soff_m = value;
      REG_INTEGRAL_LIMIT: ilim_m = value;
      default: ;
    endcase
  endtask

  // Loads all six registers once the block is idle. The unused upper byte of
  // the 8-bit gains carries random bits that the block must drop.
  task automatic set_gains(input logic [7:0] kp, input logic [7:0] ki, input logic [7:0] kd,
                           input logic [15:0] eo, input logic [15:0] so,
                           input logic [15:0] lim);
    wait_idle();
    write_reg(REG_PROP_GAIN,      {8'($urandom), kp});
    write_reg(REG_INTEG_GAIN,     {8'($urandom), ki});
    write_reg(REG_DERIV_GAIN,     {8'($urandom), kd});
    write_reg(REG_ERROR_OFFSET,   eo);
    write_reg(REG_START_OFFSET,   so);
    write_reg(REG_INTEGRAL_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  // At the reset settings with the count at zero: a large forward drive, a
  // mid-range forward duty, a saturated reverse drive, an exact zero drive
  // that must hold the reverse duty, a small reverse drive and the top set
  // point. Phase bits are set on some ticks, where they must be ignored.
  task automatic test_default_drive();
    send_word(OP_TICK, 1'b0, 1'b0, 16'd600);
    send_word(OP_TICK, 1'b0, 1'b0, 16'd470);
    send_word(OP_TICK, 1'b1, 1'b1, 16'd0);
    send_word(OP_TICK, 1'b0, 1'b0, 16'd465);
    send_word(OP_TICK, 1'b1, 1'b0, 16'd460);
    send_word(OP_TICK, 1'b0, 1'b1, 16'hFFFF);
  endtask

  // Samples that leave phase A where it was must not move the count,
  // whatever phase B does.
  task automatic test_idle_samples();
    send_word(OP_ENCODER, 1'b0, 1'b1, 16'($urandom));
    send_word(OP_ENCODER, 1'b0, 1'b0, 16'($urandom));
    send_word(OP_TICK, 1'b0, 1'b0, 16'd470);
  endtask

  // Two steps up, then fourteen down so the count wraps below zero to -12.
  // With both offsets at their negative extreme and the top set point, the
  // error overflows 26 bits and the position overflows 16 bits.
  task automatic test_count_wrap_saturation();
    logic a;
    send_word(OP_ENCODER, 1'b1, 1'b0, 16'($urandom));
    send_word(OP_ENCODER, 1'b0, 1'b1, 16'($urandom));
    repeat (14) begin
      a = ~last_a_m;
      send_word(OP_ENCODER, a, a, 16'($urandom));
    end
    set_gains(8'd20, 8'd0, 8'd0, 16'h8000, 16'h8000, 16'd1000);
    send_word(OP_TICK, 1'b0, 1'b0, 16'hFFFF);
    send_word(OP_TICK, 1'b1, 1'b1, 16'd0);
  endtask

  // Writes to the two indexes past the register map must be dropped.
  task automatic test_ignored_index();
    wait_idle();
    write_reg(REG_UNUSED_6, 16'($urandom));
    write_reg(REG_UNUSED_7, 16'($urandom));
    cfg_valid <= 1'b0;
    send_word(OP_TICK, 1'b0, 1'b0, 16'd470);
  endtask

  // One random phase: a register setting, then a stream made mostly of
  // well-formed quadrature steps with random direction bias, ticks whose set
  // points sit near the balance point so duties land inside the range, some
  // ticks with any set point, and some random phase levels as noise. Only
  // words that change something count toward n_items.
  task automatic run_random_phase(input int n_items, input int tick_pct, input int noise_pct,
                                  input int up_pct, input cfg_choice_t choice, input bit hold);
    int          done, r;
    logic        a, b;
    longint      cnt, bal, t;
    logic [7:0]  kp, ki, kd;
    logic [15:0] eo, so, lim;
    case (choice)
      CFG_HIGH: set_gains(8'd255, 8'd255, 8'd255, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      CFG_LOW:  set_gains(8'd0, 8'd0, 8'd0, 16'h8000, 16'h8000, 16'd0);
      default: begin
        kp  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        ki  = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        kd  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        eo  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : 16'(int'($urandom_range(0, 1200)) - 600);
        so  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : 16'(int'($urandom_range(0, 1200)) - 600);
        lim = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
        set_gains(kp, ki, kd, eo, so, lim);
      end
    endcase
    if (hold) hold_req = 1'b1;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        if ($urandom_range(0, 3) == 0) begin
          t = longint'($urandom_range(0, 65535));
        end else begin
          cnt = longint'($signed(count_m));
          bal = ((cnt * POS_MUL * SCALE) / POS_DIV + longint'(soff_m) * SCALE
                 + longint'(eoff_m) * SCALE) / SCALE;
          t   = clamp_to(bal + int'($urandom_range(0, 40)) - 20, 0, 65535);
        end
        send_word(OP_TICK, 1'($urandom), 1'($urandom), 16'(t));
        done++;
      end else if (r < tick_pct + noise_pct) begin
        a = 1'($urandom);
        b = 1'($urandom);
        if (a != last_a_m) done++;
        send_word(OP_ENCODER, a, b, 16'($urandom));
      end else begin
        a = ~last_a_m;
        b = ($urandom_range(0, 99) < up_pct) ? ~a : a;
        send_word(OP_ENCODER, a, b, 16'($urandom));
        done++;
      end
    end
  endtask

  // The sink holds off for a long stretch while the source keeps offering a
  // tick-heavy stream, so the output and skid registers fill and in_tready
  // must drop without losing or duplicating a result.
  task automatic test_backpressure();
    run_random_phase(150, 60, 5, 50, CFG_RANDOM, 1'b1);
  endtask

  // Sink side: a ready pattern that switches between random modes, and the
  // long hold-off when the stimulus asks for it, counted here.
  initial begin : sink_pattern
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    mode      = SINK_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          SINK_ALWAYS: out_tready <= 1'b1;
          SINK_COIN:   out_tready <= 1'($urandom);
          SINK_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
          default:     out_tready <= ((mode_left % 6) < 3);
        endcase
      end
    end
  end

  // Every accepted output word is matched against the oldest prediction.
  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("output word with no prediction", longint'(out_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[15:0] !== want.position_deg) begin
          report_mismatch("position_deg", $signed(out_tdata[15:0]), want.position_deg);
        end
        if (out_tdata[16] !== want.reverse) begin
          report_mismatch("reverse", out_tdata[16], want.reverse);
        end
        if (out_tdata[24:17] !== want.duty) begin
          report_mismatch("duty", out_tdata[24:17], want.duty);
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    burst_left     = 0;
    idle_on        = 1'b1;
    hold_req       = 1'b0;

    kp_m       = PROP_GAIN_RST;
    ki_m       = INTEG_GAIN_RST;
    kd_m       = DERIV_GAIN_RST;
    eoff_m     = ERROR_OFFSET_RST;
    soff_m     = START_OFFSET_RST;
    ilim_m     = INTEGRAL_LIMIT_RST;
    last_a_m   = 1'b0;
    count_m    = 16'd0;
    integ_m    = 0;
    prev_err_m = 0;
    dir_m      = 1'b0;
    duty_m     = 8'd0;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 24'd0;
    in_tuser  <= OP_ENCODER;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PROP_GAIN;
    cfg_data  <= 16'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_drive();
    test_idle_samples();
    test_count_wrap_saturation();
    test_ignored_index();

    // The all-high setting walks the count upward so the position also
    // saturates at the positive end; the all-low setting pins the error.
    run_random_phase(150, 25, 10, 85, CFG_HIGH, 1'b0);
    run_random_phase(150, 25, 10, 20, CFG_LOW, 1'b0);
    run_random_phase(150, 25, 10, 50, CFG_RANDOM, 1'b0);
    // A stretch where the source never pauses.
    idle_on = 1'b0;
    run_random_phase(150, 30, 10, 60, CFG_RANDOM, 1'b0);
    idle_on = 1'b1;
    run_random_phase(150, 20, 15, 40, CFG_RANDOM, 1'b0);
    run_random_phase(150, 35, 5, 50, CFG_RANDOM, 1'b0);
    test_backpressure();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("quadrature_position_pid_drive_core_tb: PASS");
    end else begin
      $display("quadrature_position_pid_drive_core_tb: FAIL");
    end
    $finish;
  end

endmodule
